FILE: src/filtered_pressure_altimeter_unit_macros.svh
// assertion macros for the filtered pressure altimeter
`ifndef FILTERED_PRESSURE_ALTIMETER_UNIT_MACROS_SVH
`define FILTERED_PRESSURE_ALTIMETER_UNIT_MACROS_SVH

// implication checked on every clock, suspended in reset
`define FPA_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication checked on every clock, reset included
`define FPA_ASSERT_ALL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/fpa_pkg.sv
// package: widths, defaults and altitude curve generation
package fpa_pkg;

  localparam int PRESS_W = 17;
  localparam int ALT_W = 23;
  localparam int Y_W = 24;
  localparam int DIV_W = 33;
  localparam int DIV_CNT_W = 6;
  localparam int CURVE_MAX = 1024;
  localparam int CURVE_IDX_W = 11;
  localparam int WINDOW_DEFAULT = 100;
  localparam int CURVE_POINTS_DEFAULT = 64;
  localparam logic [PRESS_W-1:0] SEA_RESET = 17'd101325;
  localparam longint ALT_SCALE_CM = 4433000;
  localparam longint EXP_Q30 = 204327593;
  localparam longint ONE_Q30 = longint'(1) <<< 30;
  localparam logic signed [ALT_W-1:0] S23_MAX = 23'sh3FFFFF;
  localparam logic signed [ALT_W-1:0] S23_MIN = -23'sh400000;

  typedef logic [CURVE_MAX:0][Y_W-1:0] curve_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'h1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > x) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic longint log2_q30(input logic [63:0] v);
    int n;
    logic [63:0] m;
    logic [63:0] frac;
    n = 0;
    frac = '0;
    for (int k = 0; k < 40; k++) begin
      if ((v >> (n + 1)) != 0) n = n + 1;
    end
    m = (v << 30) >> n;
    for (int b = 29; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | (64'd1 << b);
      end
    end
    return longint'(n) * ONE_Q30 + longint'(frac);
  endfunction

  function automatic curve_t curve_build(input int points);
    curve_t c;
    logic [63:0] roots [31];
    longint lnp;
    longint l;
    longint z;
    longint k;
    longint y;
    logic [63:0] f;
    logic [63:0] m;
    c = '0;
    roots[0] = 64'd2 << 30;
    roots[1] = isqrt64(64'd1 << 61);
    for (int i = 2; i <= 30; i++) roots[i] = isqrt64(roots[i-1] << 30);
    lnp = log2_q30(64'(points));
    c[0] = Y_W'(ALT_SCALE_CM);
    for (int i = 1; i <= CURVE_MAX; i++) begin
      if (i <= points) begin
        l = ONE_Q30 + log2_q30(64'(i)) - lnp;
        z = (l * EXP_Q30 + (longint'(1) <<< 29)) >>> 30;
        k = z >>> 30;
        f = 64'(z - k * ONE_Q30);
        m = 64'(ONE_Q30);
        for (int j = 1; j <= 30; j++) begin
          if (f[30-j]) m = (m * roots[j]) >> 30;
        end
        if (k < 0) begin
          m = (k < -62) ? 64'd0 : (m >> (-k));
        end else if (k > 0) begin
          m = m << ((k > 2) ? 2 : k);
        end
        y = (ALT_SCALE_CM * (ONE_Q30 - longint'(m)) + (longint'(1) <<< 29)) >>> 30;
        c[i] = Y_W'(y);
      end
    end
    return c;
  endfunction

  function automatic logic signed [ALT_W-1:0] sat23(input logic signed [31:0] v);
    if (v > 32'(S23_MAX)) return S23_MAX;
    if (v < 32'(S23_MIN)) return S23_MIN;
    return v[ALT_W-1:0];
  endfunction

endpackage

FILE: src/fpa_ram.sv
// generic single-port-write ram with registered read
module fpa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: src/filtered_pressure_altimeter_unit.sv
// filtered pressure altimeter: boxcar mean, ratio divide, curve interpolation
// an accepted sample runs through sum, mean, a 33-step ratio divide, segment, curve fetch,
// multiply, altitude and output states; no new sample is taken until the result is loaded for output
// after reset the sample ring is zeroed slot by slot, input not ready meanwhile
// reset clears sum, write slot and zero reference and loads sea pressure 101325
module filtered_pressure_altimeter_unit #(
  parameter int WINDOW = fpa_pkg::WINDOW_DEFAULT,
  parameter int CURVE_POINTS = fpa_pkg::CURVE_POINTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,      // sea-level reference pressure
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pressure[16:0], zero fill
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // mean_pressure[16:0], altitude_cm[39:17], height_cm[62:40]
);
  import fpa_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W = PRESS_W + $clog2(WINDOW);
  localparam int REC_SH = SUM_W + $clog2(WINDOW);
  localparam int REC_W = SUM_W + 1;
  localparam logic [REC_W-1:0] REC_M = REC_W'(((longint'(1) <<< REC_SH)
      + longint'(WINDOW) - longint'(1)) / longint'(WINDOW));
  localparam curve_t CURVE = curve_build(CURVE_POINTS);

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_SUM   = 10'b0000000100,
    ST_DIVM  = 10'b0000001000,
    ST_DIVR  = 10'b0000010000,
    ST_SEG   = 10'b0000100000,
    ST_Y     = 10'b0001000000,
    ST_MUL   = 10'b0010000000,
    ST_ALT   = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [SLOT_W-1:0] clr_cnt, slot;
  logic [SUM_W-1:0] sum, sum_next;
  logic [SUM_W+REC_W-1:0] rec_prod;
  logic [PRESS_W-1:0] mean_calc;
  logic kind_q;
  logic [PRESS_W-1:0] press_q, sea, mean_q, divisor, ring_rdata;
  logic [DIV_W-1:0] div_q, q_new;
  logic [PRESS_W-1:0] div_rem;
  logic [PRESS_W:0] rem_sh, rem_new;
  logic ge;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CURVE_IDX_W-1:0] seg_q;
  logic [PRESS_W:0] f_q;
  logic [PRESS_W+CURVE_IDX_W-1:0] t_val;
  logic signed [Y_W-1:0] y0, y1;
  logic signed [43:0] prod, v_sum;
  logic signed [26:0] rounded;
  logic signed [ALT_W-1:0] alt_q, zref, height;
  logic ring_we;
  logic [SLOT_W-1:0] ring_waddr;
  logic [PRESS_W-1:0] ring_wdata;
  logic out_free;

  fpa_ram #(.WIDTH(PRESS_W), .DEPTH(WINDOW)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(slot), .rdata(ring_rdata)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    ring_we = (state == ST_CLEAR) || (state == ST_SUM);
    ring_waddr = (state == ST_CLEAR) ? clr_cnt : slot;
    ring_wdata = (state == ST_CLEAR) ? '0 : press_q;
    sum_next = sum - SUM_W'(ring_rdata) + SUM_W'(press_q);
    rec_prod = sum * REC_M;
    mean_calc = rec_prod[REC_SH +: PRESS_W];
    rem_sh = {div_rem, div_q[DIV_W-1]};
    ge = rem_sh >= {1'b0, divisor};
    rem_new = ge ? rem_sh - {1'b0, divisor} : rem_sh;
    q_new = {div_q[DIV_W-2:0], ge};
    t_val = div_q[PRESS_W-1:0] * CURVE_IDX_W'(CURVE_POINTS);
    v_sum = (44'(y0) <<< 17) + prod;
    rounded = 27'((v_sum + 44'sd65536) >>> 17);
    height = sat23(32'(24'(alt_q) - 24'(zref)));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == SLOT_W'(WINDOW - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_SUM;
      ST_SUM:   state_next = ST_DIVM;
      ST_DIVM:  state_next = ST_DIVR;
      ST_DIVR:  if (div_cnt == '0) state_next = ST_SEG;
      ST_SEG:   state_next = ST_Y;
      ST_Y:     state_next = ST_MUL;
      ST_MUL:   state_next = ST_ALT;
      ST_ALT:   state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      slot <= '0;
      sum <= '0;
      zref <= '0;
      sea <= SEA_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) sea <= cfg_wdata;
      if ((state == ST_OUT) && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_SUM: begin
          sum <= sum_next;
          slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
        end
        ST_OUT: if (out_free && kind_q) zref <= alt_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        kind_q <= s_axis_tuser;
        press_q <= s_axis_tdata[PRESS_W-1:0];
      end
      ST_DIVM: begin
        mean_q <= mean_calc;
        div_q <= {mean_calc, 16'b0};
        div_rem <= '0;
        divisor <= sea;
        div_cnt <= DIV_CNT_W'(DIV_W - 1);
      end
      ST_DIVR: begin
        div_cnt <= div_cnt - 1'b1;
        div_q <= q_new;
        div_rem <= rem_new[PRESS_W-1:0];
      end
      ST_SEG: begin
        if (|div_q[DIV_W-1:PRESS_W]) begin
          seg_q <= CURVE_IDX_W'(CURVE_POINTS - 1);
          f_q <= {1'b1, {PRESS_W{1'b0}}};
        end else begin
          seg_q <= t_val[PRESS_W+CURVE_IDX_W-1:PRESS_W];
          f_q <= {1'b0, t_val[PRESS_W-1:0]};
        end
      end
      ST_Y: begin
        y0 <= $signed(CURVE[seg_q]);
        y1 <= $signed(CURVE[seg_q + 1'b1]);
      end
      ST_MUL: prod <= 44'((25'(y1) - 25'(y0)) * $signed({1'b0, f_q}));
      ST_ALT: alt_q <= sat23(32'(rounded));
      ST_OUT: if (out_free) begin
        m_axis_tdata <= {1'b0, height, alt_q, mean_q};
      end
      default: ;
    endcase
  end
endmodule

FILE: src/fpa_checker.sv
// port-level checker for the filtered pressure altimeter, with bind
`include "filtered_pressure_altimeter_unit_macros.svh"

module fpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  `FPA_ASSERT_ALL(a_reset_no_out, rst, !m_axis_tvalid && !s_axis_tready, "busy after reset")
  `FPA_ASSERT_RST(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
  `FPA_ASSERT_RST(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")
  `FPA_ASSERT_RST(a_no_early_out, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result too early")
endmodule

bind filtered_pressure_altimeter_unit fpa_checker u_fpa_checker (.*);

FILE: verif/testbench.sv
// testbench for the filtered pressure altimeter: directed table, random runs, self-predicted
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int RING_LEN = 100;
  localparam int SEGMENTS = 64;
  localparam bit KIND_PLAIN = 1'b0;
  localparam bit KIND_ZERO = 1'b1;
  localparam longint Q30 = longint'(1) <<< 30;

  typedef struct {
    logic [PRESS_W-1:0] mean;
    logic signed [ALT_W-1:0] alt;
    logic signed [ALT_W-1:0] height;
  } reading_t;

  typedef struct {
    bit kind;
    logic [PRESS_W-1:0] pressure;
    bit typed;
    reading_t want;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [16:0] cfg_wdata;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [63:0] m_axis_tdata;

  longint altitude_curve [0:SEGMENTS];
  logic [PRESS_W-1:0] pressure_ring [RING_LEN];
  longint pressure_sum;
  int ring_slot;
  longint zero_ref_cm;
  logic [16:0] sea_level;
  reading_t pending_readings [$];
  int mismatches;
  int items_sent;
  int readings_seen;
  int zero_loads;
  bit calm;

  filtered_pressure_altimeter_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("filtered_pressure_altimeter_unit test failed");
    $finish;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint fixed_log2(longint unsigned v);
    int n;
    longint unsigned m;
    longint unsigned fr;
    n = 0;
    fr = 0;
    while (n < 40 && (v >> (n + 1)) != 0) n++;
    m = (v << 30) >> n;
    for (int b = 29; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        fr = fr | (64'd1 << b);
      end
    end
    return longint'(n) * Q30 + longint'(fr);
  endfunction

  function automatic longint round_down(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  task automatic fill_curve();
    longint unsigned rt [31];
    longint lnp;
    longint z;
    longint k;
    longint unsigned f;
    longint unsigned m;
    rt[0] = 64'd2 << 30;
    rt[1] = floor_root(64'd1 << 61);
    for (int i = 2; i <= 30; i++) rt[i] = floor_root(rt[i-1] << 30);
    lnp = fixed_log2(SEGMENTS);
    altitude_curve[0] = 4433000;
    for (int i = 1; i <= SEGMENTS; i++) begin
      z = round_down((Q30 + fixed_log2(i) - lnp) * 204327593, 30);
      k = z >>> 30;
      f = longint'(z - k * Q30);
      m = Q30;
      for (int j = 1; j <= 30; j++)
        if (f[30-j]) m = (m * rt[j]) >> 30;
      if (k < 0) m = (k < -62) ? 0 : (m >> (-k));
      else if (k > 0) m = m << ((k > 2) ? 2 : k);
      altitude_curve[i] = round_down(longint'(4433000) * (Q30 - longint'(m)), 30);
    end
  endtask

  function automatic longint clamp23(longint v);
    if (v > 4194303) return 4194303;
    if (v < -4194304) return -4194304;
    return v;
  endfunction

  function automatic longint mean_to_altitude(longint unsigned mean);
    longint unsigned ratio;
    longint unsigned seg;
    longint unsigned f;
    longint unsigned t;
    ratio = (sea_level == 0) ? (64'd1 << 17) : ((mean << 16) / sea_level);
    if (ratio >= (64'd1 << 17)) begin
      seg = SEGMENTS - 1;
      f = 64'd1 << 17;
    end else begin
      t = ratio * SEGMENTS;
      seg = t >> 17;
      f = t & ((64'd1 << 17) - 1);
    end
    return clamp23(round_down(altitude_curve[seg] * (longint'(1) <<< 17)
        + (altitude_curve[seg+1] - altitude_curve[seg]) * longint'(f), 17));
  endfunction

  function automatic reading_t take_sample(bit kind, logic [PRESS_W-1:0] p);
    reading_t r;
    longint a;
    pressure_sum = pressure_sum - pressure_ring[ring_slot] + p;
    pressure_ring[ring_slot] = p;
    ring_slot = (ring_slot + 1 >= RING_LEN) ? 0 : ring_slot + 1;
    r.mean = PRESS_W'(pressure_sum / RING_LEN);
    a = mean_to_altitude(r.mean);
    r.alt = ALT_W'(a);
    r.height = ALT_W'(clamp23(a - zero_ref_cm));
    if (kind == KIND_ZERO) zero_ref_cm = a;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at reading %0d: %s got %0d expected %0d", readings_seen, what, got, want);
    mismatches++;
  endtask

  task automatic send_sample(bit kind, logic [PRESS_W-1:0] p, bit typed, reading_t want);
    reading_t r;
    while (!calm && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, p};
    s_axis_tuser <= kind;
    do @(posedge clk); while (!s_axis_tready);
    r = take_sample(kind, p);
    pending_readings.push_back(typed ? want : r);
    items_sent++;
    if (kind == KIND_ZERO) zero_loads++;
  endtask

  task automatic drain_and_set(logic [16:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sea_level = v;
  endtask

  always @(posedge clk) begin
    reading_t w;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 13);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_readings.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          w = pending_readings.pop_front();
          if (m_axis_tdata[16:0] !== w.mean)
            report("mean", longint'(m_axis_tdata[16:0]), longint'(w.mean));
          if ($signed(m_axis_tdata[39:17]) !== w.alt)
            report("altitude", longint'($signed(m_axis_tdata[39:17])), longint'(w.alt));
          if ($signed(m_axis_tdata[62:40]) !== w.height)
            report("height", longint'($signed(m_axis_tdata[62:40])), longint'(w.height));
        end
        readings_seen++;
      end
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    reading_t none;
    logic [16:0] seas [7];
    int base;
    int run_left;
    logic [PRESS_W-1:0] p;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    mismatches = 0;
    items_sent = 0;
    readings_seen = 0;
    zero_loads = 0;
    calm = 1'b0;
    none = '{default: 0};
    fill_curve();
    foreach (pressure_ring[i]) pressure_ring[i] = '0;
    pressure_sum = 0;
    ring_slot = 0;
    zero_ref_cm = 0;
    sea_level = 17'd101325;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // after reset: all-zero ring saturates altitude high
    rows.push_back('{KIND_PLAIN, 17'd0, 1, '{17'd0, 23'sd4194303, 23'sd4194303}});
    rows.push_back('{KIND_ZERO, 17'd0, 1, '{17'd0, 23'sd4194303, 23'sd4194303}});
    rows.push_back('{KIND_PLAIN, 17'd0, 1, '{17'd0, 23'sd4194303, 23'sd0}});
    rows.push_back('{KIND_PLAIN, 17'h1FFFF, 0, none});
    rows.push_back('{KIND_PLAIN, 17'h15555, 0, none});
    rows.push_back('{KIND_ZERO, 17'h0AAAA, 0, none});
    rows.push_back('{KIND_PLAIN, 17'd1000, 0, none});
    rows.push_back('{KIND_PLAIN, 17'd120000, 0, none});
    rows.push_back('{KIND_ZERO, 17'd120000, 0, none});
    rows.push_back('{KIND_PLAIN, 17'd101325, 0, none});
    rows.push_back('{KIND_PLAIN, 17'd65536, 0, none});
    rows.push_back('{KIND_PLAIN, 17'h1FFFF, 0, none});
    rows.push_back('{KIND_ZERO, 17'd1, 0, none});
    rows.push_back('{KIND_PLAIN, 17'd99999, 0, none});
    foreach (rows[i]) begin
      rw = rows[i];
      send_sample(rw.kind, rw.pressure, rw.typed, rw.want);
    end

    seas = '{17'd101325, 17'd90000, 17'd110000, 17'd0, 17'h1FFFF, 17'd30000, 17'd1};
    base = 100000;
    run_left = 0;
    for (int ph = 0; ph < 7; ph++) begin
      drain_and_set(seas[ph]);
      for (int n = 0; n < 205; n++) begin
        calm = (ph == 2);
        if (run_left == 0) begin
          run_left = $urandom_range(150, 20);
          base = $urandom_range(120000, 1000);
        end
        run_left--;
        if ($urandom_range(99) < 10) p = PRESS_W'($urandom_range(17'h1FFFF, 0));
        else p = PRESS_W'($urandom_range(base + 300, base - 300));
        send_sample($urandom_range(99) < 6 ? KIND_ZERO : KIND_PLAIN, p, 0, none);
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d samples (%0d zero loads) over 7 sea-level settings, %0d readings",
             items_sent, zero_loads, readings_seen);
    if (mismatches == 0) begin
      $display("filtered_pressure_altimeter_unit test passed");
    end else begin
      $display("filtered_pressure_altimeter_unit test failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+src
src/fpa_pkg.sv
src/fpa_ram.sv
src/filtered_pressure_altimeter_unit.sv
src/fpa_checker.sv
verif/testbench.sv
